@@ hw/rtl/lbfv_pkg.sv @@
// Shared types, constants and helper functions for the Lorentz boost pipeline.
// Used by lorentz_boost_four_vector_top; depends on nothing else.
package lbfv_pkg;

   // Square root of 1 - beta^2: one result bit per step, two steps per stage.
   localparam int SQ_STEPS  = 31;
   localparam int SQ_PER    = 2;
   localparam int SQ_STAGES = (SQ_STEPS + SQ_PER - 1) / SQ_PER;

   // Gamma = 2^63 / s: one quotient bit per step, four steps per stage.
   localparam int GD_STEPS  = 48;
   localparam int GD_PER    = 4;
   localparam int GD_STAGES = (GD_STEPS + GD_PER - 1) / GD_PER;

   // (gamma-1)*dot / (4*beta^2): 96-bit dividend, four steps per stage.
   localparam int QD_STEPS  = 96;
   localparam int QD_PER    = 4;
   localparam int QD_STAGES = (QD_STEPS + QD_PER - 1) / QD_PER;

   // Status codes of a result item.
   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_BAD = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   // Magnitude limit of the wide intermediates.
   localparam logic [62:0] MAG_CAP = {1'b1, 62'd0};

   localparam logic signed [64:0] MAX32 = {34'd0, {31{1'b1}}};
   localparam logic signed [64:0] MIN32 = {{34{1'b1}}, 31'd0};

   // Values that travel with an item down the pipeline.
   typedef struct packed {
      logic [31:0]       t;
      logic [2:0][31:0]  r;
      logic [2:0][15:0]  b;
      logic              bad;
      logic              zero;
      logic              sat;
      logic [31:0]       b2;
      logic [48:0]       dot;
      logic [49:0]       diff;
      logic [47:0]       g;
      logic [63:0]       t2;
      logic [31:0]       ctp;
      logic              kneg;
      logic [63:0]       kmag;
   } item_type;

   typedef struct packed {
      logic        hit;
      logic [62:0] mag;
   } cap_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] val;
   } clip_type;

   // Limit a magnitude to MAG_CAP and report whether it was hit.
   function automatic cap_type cap_mag(input logic [127:0] m);
      cap_type c;
      if (m > {65'd0, MAG_CAP}) begin
         c.hit = 1'b1;
         c.mag = MAG_CAP;
      end else begin
         c.hit = 1'b0;
         c.mag = m[62:0];
      end
      return c;
   endfunction

   // Turn a magnitude and a sign into a two's complement value.
   function automatic logic [63:0] apply_sign(input logic neg, input logic [62:0] mag);
      logic [63:0] v;
      v = {1'b0, mag};
      return neg ? (64'd0 - v) : v;
   endfunction

   // Saturate a signed value to the signed 32-bit range.
   function automatic clip_type clip32(input logic signed [64:0] v);
      clip_type c;
      if (v > MAX32) begin
         c.hit = 1'b1;
         c.val = 32'h7FFF_FFFF;
      end else if (v < MIN32) begin
         c.hit = 1'b1;
         c.val = 32'h8000_0000;
      end else begin
         c.hit = 1'b0;
         c.val = v[31:0];
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/lorentz_boost_four_vector_top.sv @@
// Lorentz boost of a Q16.16 four-vector by a Q0.15 velocity, fully pipelined.
// Depends on lbfv_pkg for types, constants and saturation helpers.

// The block accepts one item per clock cycle while req_stall is low and returns
// each result in order. Most of its depth lies in the iterative units laid out as
// pipeline stages: a 16-stage square root of 1 - beta^2, a 12-stage divider that
// forms gamma, and a 24-stage divider for the (gamma-1)*dot/beta^2 term, plus
// the multiply and rounding stages around them. A stall on the result side
// freezes the whole pipeline; nothing is lost or repeated. A velocity with a
// component at -1 or with beta squared at or above one returns zeros with status
// 1, a zero velocity passes the vector through, and a saturated result has
// status 2.
module lorentz_boost_four_vector_top
   import lbfv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_time_component,
   input  logic signed [31:0]  req_space_x,
   input  logic signed [31:0]  req_space_y,
   input  logic signed [31:0]  req_space_z,
   input  logic signed [15:0]  req_velocity_x,
   input  logic signed [15:0]  req_velocity_y,
   input  logic signed [15:0]  req_velocity_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_boosted_time,
   output logic signed [31:0]  rsp_boosted_x,
   output logic signed [31:0]  rsp_boosted_y,
   output logic signed [31:0]  rsp_boosted_z,
   output logic [1:0]          rsp_status
);

   // Global advance: every stage moves unless a finished item is held.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // ---------------------------------------------------------------------------
   // Stage A: squares of beta and products beta_i * r_i.
   item_type          a_in, a_item_ff;
   logic [2:0][30:0]  a_sq_in, a_sq_ff;
   logic [2:0][47:0]  a_pr_in, a_pr_ff;
   logic              a_valid_ff;

   always_comb begin
      a_in      = '0;
      a_in.t    = req_time_component;
      a_in.r[0] = req_space_x;
      a_in.r[1] = req_space_y;
      a_in.r[2] = req_space_z;
      a_in.b[0] = req_velocity_x;
      a_in.b[1] = req_velocity_y;
      a_in.b[2] = req_velocity_z;
      for (int i = 0; i < 3; i++) begin
         a_sq_in[i] = 31'($signed({{16{a_in.b[i][15]}}, a_in.b[i]})
                        * $signed({{16{a_in.b[i][15]}}, a_in.b[i]}));
         a_pr_in[i] = $signed({{32{a_in.b[i][15]}}, a_in.b[i]})
                    * $signed({{16{a_in.r[i][31]}}, a_in.r[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff <= a_in;
         a_sq_ff   <= a_sq_in;
         a_pr_ff   <= a_pr_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage B: beta squared, dot product and the physical checks.
   item_type b_in, b_item_ff;
   logic     b_valid_ff;

   always_comb begin
      b_in     = a_item_ff;
      b_in.b2  = {1'b0, a_sq_ff[0]} + {1'b0, a_sq_ff[1]} + {1'b0, a_sq_ff[2]};
      b_in.dot = {a_pr_ff[0][47], a_pr_ff[0]} + {a_pr_ff[1][47], a_pr_ff[1]}
               + {a_pr_ff[2][47], a_pr_ff[2]};
      b_in.bad = (a_item_ff.b[0] == 16'h8000) || (a_item_ff.b[1] == 16'h8000)
              || (a_item_ff.b[2] == 16'h8000) || (b_in.b2 >= 32'h4000_0000);
      b_in.zero = (b_in.b2 == 32'd0);
      b_in.sat  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_item_ff <= b_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Square root stages: s = floor(sqrt((2^30 - b2) * 2^32)).
   item_type     sq_item_src [SQ_STAGES];
   logic [61:0]  sq_rad_src  [SQ_STAGES];
   logic [32:0]  sq_rem_src  [SQ_STAGES];
   logic [30:0]  sq_root_src [SQ_STAGES];
   logic         sq_valid_src[SQ_STAGES];
   item_type     sq_item_ff  [SQ_STAGES];
   logic [61:0]  sq_rad_ff   [SQ_STAGES];
   logic [32:0]  sq_rem_ff   [SQ_STAGES];
   logic [30:0]  sq_root_ff  [SQ_STAGES];
   logic         sq_valid_ff [SQ_STAGES];
   logic [31:0]  one_minus_b2;

   assign one_minus_b2 = 32'h4000_0000 - b_item_ff.b2;

   for (genvar st = 0; st < SQ_STAGES; st++) begin : g_sq
      logic [61:0] rad_in;
      logic [32:0] rem_in;
      logic [30:0] root_in;

      if (st == 0) begin : g_src
         // First stage also forms ct*2^15 - dot for the time term.
         always_comb begin
            sq_item_src[st]      = b_item_ff;
            sq_item_src[st].diff = {{3{b_item_ff.t[31]}}, b_item_ff.t, 15'd0}
                                 - {b_item_ff.dot[48], b_item_ff.dot};
            sq_rad_src[st]       = {one_minus_b2[29:0], 32'd0};
            sq_rem_src[st]       = '0;
            sq_root_src[st]      = '0;
            sq_valid_src[st]     = b_valid_ff;
         end
      end else begin : g_src
         always_comb begin
            sq_item_src[st]  = sq_item_ff[st-1];
            sq_rad_src[st]   = sq_rad_ff[st-1];
            sq_rem_src[st]   = sq_rem_ff[st-1];
            sq_root_src[st]  = sq_root_ff[st-1];
            sq_valid_src[st] = sq_valid_ff[st-1];
         end
      end

      // One root bit per step from the next pair of radicand bits.
      always_comb begin
         logic [34:0] acc;
         logic [34:0] trial;
         rad_in  = sq_rad_src[st];
         rem_in  = sq_rem_src[st];
         root_in = sq_root_src[st];
         for (int j = 0; j < SQ_PER; j++) begin
            if (st * SQ_PER + j < SQ_STEPS) begin
               acc    = {rem_in, rad_in[61:60]};
               rad_in = {rad_in[59:0], 2'b00};
               trial  = {2'b00, root_in, 2'b01};
               if (acc >= trial) begin
                  acc     = acc - trial;
                  root_in = {root_in[29:0], 1'b1};
               end else begin
                  root_in = {root_in[29:0], 1'b0};
               end
               rem_in = acc[32:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[st] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[st] <= sq_valid_src[st];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_item_ff[st] <= sq_item_src[st];
            sq_rad_ff[st]  <= rad_in;
            sq_rem_ff[st]  <= rem_in;
            sq_root_ff[st] <= root_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Gamma divider stages: g = floor(2^63 / s), quotient below 2^48.
   item_type     gd_item_src [GD_STAGES];
   logic [30:0]  gd_s_src    [GD_STAGES];
   logic [31:0]  gd_rem_src  [GD_STAGES];
   logic [47:0]  gd_q_src    [GD_STAGES];
   logic         gd_valid_src[GD_STAGES];
   item_type     gd_item_ff  [GD_STAGES];
   logic [30:0]  gd_s_ff     [GD_STAGES];
   logic [31:0]  gd_rem_ff   [GD_STAGES];
   logic [47:0]  gd_q_ff     [GD_STAGES];
   logic         gd_valid_ff [GD_STAGES];

   for (genvar st = 0; st < GD_STAGES; st++) begin : g_gd
      logic [31:0] rem_in;
      logic [47:0] q_in;

      if (st == 0) begin : g_src
         // The leading dividend bits 2^63 >> 48 form the starting remainder.
         always_comb begin
            gd_item_src[st]  = sq_item_ff[SQ_STAGES-1];
            gd_s_src[st]     = sq_root_ff[SQ_STAGES-1];
            gd_rem_src[st]   = 32'h0000_8000;
            gd_q_src[st]     = '0;
            gd_valid_src[st] = sq_valid_ff[SQ_STAGES-1];
         end
      end else begin : g_src
         always_comb begin
            gd_item_src[st]  = gd_item_ff[st-1];
            gd_s_src[st]     = gd_s_ff[st-1];
            gd_rem_src[st]   = gd_rem_ff[st-1];
            gd_q_src[st]     = gd_q_ff[st-1];
            gd_valid_src[st] = gd_valid_ff[st-1];
         end
      end

      // Restoring division, one quotient bit per step.
      always_comb begin
         logic [32:0] acc;
         rem_in = gd_rem_src[st];
         q_in   = gd_q_src[st];
         for (int j = 0; j < GD_PER; j++) begin
            if (st * GD_PER + j < GD_STEPS) begin
               acc = {rem_in, 1'b0};
               if (acc >= {2'b00, gd_s_src[st]}) begin
                  acc  = acc - {2'b00, gd_s_src[st]};
                  q_in = {q_in[46:0], 1'b1};
               end else begin
                  q_in = {q_in[46:0], 1'b0};
               end
               rem_in = acc[31:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            gd_valid_ff[st] <= 1'b0;
         end else if (adv) begin
            gd_valid_ff[st] <= gd_valid_src[st];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            gd_item_ff[st] <= gd_item_src[st];
            gd_s_ff[st]    <= gd_s_src[st];
            gd_rem_ff[st]  <= rem_in;
            gd_q_ff[st]    <= q_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage MA: partial products of (g-1)*|dot|, g*|ct| and g*|diff|.
   item_type          ma_in, ma_item_ff;
   logic [47:0]       gm1, dmag;
   logic [48:0]       dneg;
   logic [31:0]       tmag;
   logic [49:0]       fneg;
   logic [48:0]       fmag;
   logic [3:0][47:0]  ma_pd_in, ma_pd_ff;
   logic [1:0][55:0]  ma_pt_in, ma_pt_ff;
   logic [3:0][48:0]  ma_pf_in, ma_pf_ff;
   logic              ma_valid_ff;

   always_comb begin
      ma_in   = gd_item_ff[GD_STAGES-1];
      ma_in.g = gd_q_ff[GD_STAGES-1];
      gm1     = ma_in.g - 48'h0001_0000_0000;
      dneg    = 49'd0 - ma_in.dot;
      dmag    = ma_in.dot[48] ? dneg[47:0] : ma_in.dot[47:0];
      tmag    = ma_in.t[31] ? (32'd0 - ma_in.t) : ma_in.t;
      fneg    = 50'd0 - ma_in.diff;
      fmag    = ma_in.diff[49] ? fneg[48:0] : ma_in.diff[48:0];
      ma_pd_in[0] = gm1[23:0]  * dmag[23:0];
      ma_pd_in[1] = gm1[23:0]  * dmag[47:24];
      ma_pd_in[2] = gm1[47:24] * dmag[23:0];
      ma_pd_in[3] = gm1[47:24] * dmag[47:24];
      ma_pt_in[0] = ma_in.g[23:0]  * tmag;
      ma_pt_in[1] = ma_in.g[47:24] * tmag;
      ma_pf_in[0] = ma_in.g[23:0]  * fmag[23:0];
      ma_pf_in[1] = ma_in.g[23:0]  * fmag[48:24];
      ma_pf_in[2] = ma_in.g[47:24] * fmag[23:0];
      ma_pf_in[3] = ma_in.g[47:24] * fmag[48:24];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ma_valid_ff <= 1'b0;
      end else if (adv) begin
         ma_valid_ff <= gd_valid_ff[GD_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_item_ff <= ma_in;
         ma_pd_ff   <= ma_pd_in;
         ma_pt_ff   <= ma_pt_in;
         ma_pf_ff   <= ma_pf_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage MB: sum the partial products into full products.
   item_type     mb_item_ff;
   logic [95:0]  mb_p1_in, mb_p1_ff;
   logic [79:0]  mb_p2_in, mb_p2_ff;
   logic [97:0]  mb_p3_in, mb_p3_ff;
   logic         mb_valid_ff;

   always_comb begin
      mb_p1_in = {48'd0, ma_pd_ff[0]} + {24'd0, ma_pd_ff[1], 24'd0}
               + {24'd0, ma_pd_ff[2], 24'd0} + {ma_pd_ff[3], 48'd0};
      mb_p2_in = {24'd0, ma_pt_ff[0]} + {ma_pt_ff[1], 24'd0};
      mb_p3_in = {49'd0, ma_pf_ff[0]} + {25'd0, ma_pf_ff[1], 24'd0}
               + {25'd0, ma_pf_ff[2], 24'd0} + {1'b0, ma_pf_ff[3], 48'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mb_valid_ff <= 1'b0;
      end else if (adv) begin
         mb_valid_ff <= ma_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mb_item_ff <= ma_item_ff;
         mb_p1_ff   <= mb_p1_in;
         mb_p2_ff   <= mb_p2_in;
         mb_p3_ff   <= mb_p3_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage MC: round gamma*ct into T2 and form the boosted time.
   item_type     mc_in, mc_item_ff;
   logic [95:0]  mc_p1_ff;
   logic         mc_valid_ff;
   logic [63:0]  t2_rnd;
   logic [51:0]  ct_rnd;
   cap_type      t2_cap, ct_cap;
   logic [63:0]  ct_val;
   clip_type     ct_clip;

   always_comb begin
      mc_in   = mb_item_ff;
      t2_rnd  = {1'b0, mb_p2_ff[79:17]} + {63'd0, mb_p2_ff[16]};
      t2_cap  = cap_mag({64'd0, t2_rnd});
      mc_in.t2 = apply_sign(mb_item_ff.t[31], t2_cap.mag);
      ct_rnd  = {1'b0, mb_p3_ff[97:47]} + {51'd0, mb_p3_ff[46]};
      ct_cap  = cap_mag({76'd0, ct_rnd});
      ct_val  = apply_sign(mb_item_ff.diff[49], ct_cap.mag);
      ct_clip = clip32({ct_val[63], ct_val});
      mc_in.ctp = ct_clip.val;
      mc_in.sat = mb_item_ff.sat | t2_cap.hit | ct_cap.hit | ct_clip.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_valid_ff <= 1'b0;
      end else if (adv) begin
         mc_valid_ff <= mb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mc_item_ff <= mc_in;
         mc_p1_ff   <= mb_p1_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Divider stages: (gamma-1)*|dot| / (4*b2), dividend shifted out as the
   // quotient shifts in.
   item_type     qd_item_src [QD_STAGES];
   logic [95:0]  qd_nq_src   [QD_STAGES];
   logic [31:0]  qd_rem_src  [QD_STAGES];
   logic         qd_valid_src[QD_STAGES];
   item_type     qd_item_ff  [QD_STAGES];
   logic [95:0]  qd_nq_ff    [QD_STAGES];
   logic [31:0]  qd_rem_ff   [QD_STAGES];
   logic         qd_valid_ff [QD_STAGES];

   for (genvar st = 0; st < QD_STAGES; st++) begin : g_qd
      logic [95:0] nq_in;
      logic [31:0] rem_in;
      logic [31:0] dvs;

      if (st == 0) begin : g_src
         always_comb begin
            qd_item_src[st]  = mc_item_ff;
            qd_nq_src[st]    = mc_p1_ff;
            qd_rem_src[st]   = '0;
            qd_valid_src[st] = mc_valid_ff;
         end
      end else begin : g_src
         always_comb begin
            qd_item_src[st]  = qd_item_ff[st-1];
            qd_nq_src[st]    = qd_nq_ff[st-1];
            qd_rem_src[st]   = qd_rem_ff[st-1];
            qd_valid_src[st] = qd_valid_ff[st-1];
         end
      end

      assign dvs = {qd_item_src[st].b2[29:0], 2'b00};

      // Restoring division, one quotient bit per step.
      always_comb begin
         logic [32:0] acc;
         nq_in  = qd_nq_src[st];
         rem_in = qd_rem_src[st];
         for (int j = 0; j < QD_PER; j++) begin
            if (st * QD_PER + j < QD_STEPS) begin
               acc   = {rem_in, nq_in[95]};
               nq_in = {nq_in[94:0], 1'b0};
               if (acc >= {1'b0, dvs}) begin
                  acc      = acc - {1'b0, dvs};
                  nq_in[0] = 1'b1;
               end
               rem_in = acc[31:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qd_valid_ff[st] <= 1'b0;
         end else if (adv) begin
            qd_valid_ff[st] <= qd_valid_src[st];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            qd_item_ff[st] <= qd_item_src[st];
            qd_nq_ff[st]   <= nq_in;
            qd_rem_ff[st]  <= rem_in;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage K1: round the quotient to nearest and sign it into T1.
   item_type     k1_in, k1_item_ff;
   logic [63:0]  k1_t1_in, k1_t1_ff;
   logic         k1_valid_ff;
   logic [31:0]  k1_dvs;
   logic         k1_up;
   logic [96:0]  t1_rnd;
   cap_type      t1_cap;

   always_comb begin
      k1_in    = qd_item_ff[QD_STAGES-1];
      k1_dvs   = {k1_in.b2[29:0], 2'b00};
      k1_up    = {qd_rem_ff[QD_STAGES-1], 1'b0} >= {1'b0, k1_dvs};
      t1_rnd   = {1'b0, qd_nq_ff[QD_STAGES-1]} + {96'd0, k1_up};
      t1_cap   = cap_mag({31'd0, t1_rnd});
      k1_t1_in = apply_sign(k1_in.dot[48], t1_cap.mag);
      k1_in.sat = qd_item_ff[QD_STAGES-1].sat | t1_cap.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_valid_ff <= 1'b0;
      end else if (adv) begin
         k1_valid_ff <= qd_valid_ff[QD_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k1_item_ff <= k1_in;
         k1_t1_ff   <= k1_t1_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage K2: k = T1 - T2, kept as sign and magnitude.
   item_type     k2_in, k2_item_ff;
   logic         k2_valid_ff;
   logic [64:0]  kk, kk_neg;

   always_comb begin
      k2_in      = k1_item_ff;
      kk         = {k1_t1_ff[63], k1_t1_ff} - {k1_item_ff.t2[63], k1_item_ff.t2};
      kk_neg     = 65'd0 - kk;
      k2_in.kneg = kk[64];
      k2_in.kmag = kk[64] ? kk_neg[63:0] : kk[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k2_valid_ff <= 1'b0;
      end else if (adv) begin
         k2_valid_ff <= k1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         k2_item_ff <= k2_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage PM: partial products |beta_i| * |k| in two 32-bit halves.
   item_type               pm_item_ff;
   logic [2:0][1:0][47:0]  pm_in, pm_ff;
   logic [2:0][15:0]       bmag;
   logic                   pm_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bmag[i]     = k2_item_ff.b[i][15] ? (16'd0 - k2_item_ff.b[i]) : k2_item_ff.b[i];
         pm_in[i][0] = bmag[i] * k2_item_ff.kmag[31:0];
         pm_in[i][1] = bmag[i] * k2_item_ff.kmag[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_valid_ff <= 1'b0;
      end else if (adv) begin
         pm_valid_ff <= k2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pm_item_ff <= k2_item_ff;
         pm_ff      <= pm_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage PS: full products |beta_i| * |k|.
   item_type          ps_item_ff;
   logic [2:0][79:0]  ps_in, ps_ff;
   logic              ps_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ps_in[i] = {32'd0, pm_ff[i][0]} + {pm_ff[i][1], 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_valid_ff <= 1'b0;
      end else if (adv) begin
         ps_valid_ff <= pm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ps_item_ff <= pm_item_ff;
         ps_ff      <= ps_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage PR: round beta_i * k to Q16.16 and apply its sign.
   item_type          pr_in, pr_item_ff;
   logic [2:0][63:0]  pr_p_in, pr_p_ff;
   logic [2:0][50:0]  p_rnd;
   cap_type [2:0]     p_cap;
   logic              pr_valid_ff;

   always_comb begin
      pr_in = ps_item_ff;
      for (int i = 0; i < 3; i++) begin
         p_rnd[i]   = {1'b0, ps_ff[i][79:30]} + {50'd0, ps_ff[i][29]};
         p_cap[i]   = cap_mag({77'd0, p_rnd[i]});
         pr_p_in[i] = apply_sign(ps_item_ff.b[i][15] ^ ps_item_ff.kneg, p_cap[i].mag);
      end
      pr_in.sat = ps_item_ff.sat | p_cap[0].hit | p_cap[1].hit | p_cap[2].hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else if (adv) begin
         pr_valid_ff <= ps_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_item_ff <= pr_in;
         pr_p_ff    <= pr_p_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Output register: add to r_i, saturate, and apply the special cases.
   logic [2:0][31:0]  out_r_in, out_r_ff;
   logic [31:0]       out_t_in, out_t_ff;
   logic [1:0]        out_st_in, out_st_ff;
   logic [2:0][64:0]  r_sum;
   clip_type [2:0]    r_clip;
   logic              fin_sat;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r_sum[i]  = {{33{pr_item_ff.r[i][31]}}, pr_item_ff.r[i]}
                   + {pr_p_ff[i][63], pr_p_ff[i]};
         r_clip[i] = clip32(r_sum[i]);
      end
      fin_sat = pr_item_ff.sat | r_clip[0].hit | r_clip[1].hit | r_clip[2].hit;
      if (pr_item_ff.bad) begin
         out_t_in  = '0;
         out_r_in  = '0;
         out_st_in = ST_BAD;
      end else if (pr_item_ff.zero) begin
         out_t_in  = pr_item_ff.t;
         out_r_in  = pr_item_ff.r;
         out_st_in = ST_OK;
      end else begin
         out_t_in = pr_item_ff.ctp;
         for (int i = 0; i < 3; i++) begin
            out_r_in[i] = r_clip[i].val;
         end
         out_st_in = fin_sat ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= pr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_t_ff  <= out_t_in;
         out_r_ff  <= out_r_in;
         out_st_ff <= out_st_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_boosted_time = out_t_ff;
   assign rsp_boosted_x    = out_r_ff[0];
   assign rsp_boosted_y    = out_r_ff[1];
   assign rsp_boosted_z    = out_r_ff[2];
   assign rsp_status       = out_st_ff;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for lorentz_boost_four_vector_top: directed and random four-vectors.
// Depends on lbfv_pkg and the block under test; holds its own fixed-point boost predictor.
module tb
   import lbfv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam logic [127:0] CAP_WIDE = 128'd1 << 62;

   typedef struct {
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [15:0] bx;
      logic [15:0] by;
      logic [15:0] bz;
   } vec_item_type;

   typedef struct {
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [1:0]  status;
   } boost_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_time_component = '0;
   logic signed [31:0] req_space_x = '0, req_space_y = '0, req_space_z = '0;
   logic signed [15:0] req_velocity_x = '0, req_velocity_y = '0, req_velocity_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_boosted_time, rsp_boosted_x, rsp_boosted_y, rsp_boosted_z;
   logic [1:0] rsp_status;

   vec_item_type   pending_vectors[$];
   boost_item_type expected_boosts[$];
   int  error_count = 0;
   int  idle_count = 0;
   bit  stimulus_done = 1'b0;
   bit  steady_phase = 1'b0;

   // Stall as seen at the last rising edge, so the driver knows what was taken.
   logic req_stall_q = 1'b1;

   lorentz_boost_four_vector_top uut (.*);

   // Clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Magnitude of a signed value.
   function automatic logic [127:0] mag(input logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Round a magnitude right by sh bits, half up.
   function automatic logic [127:0] shr_round(input logic [127:0] m, input int sh);
      return (m >> sh) + ((m >> (sh - 1)) & 128'd1);
   endfunction

   // Cap a magnitude and apply a sign.
   function automatic logic signed [127:0] capped(input logic [127:0] m, input bit neg,
                                                  inout bit sat);
      if (m > CAP_WIDE) begin
         m = CAP_WIDE;
         sat = 1'b1;
      end
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // Clamp to the signed 32-bit range.
   function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
      if (v > 128'sh7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -128'sh8000_0000) begin
         sat = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // Integer square root of a 64-bit value.
   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Predict the boosted four-vector for one input.
   function automatic boost_item_type boost_vector(input vec_item_type v);
      boost_item_type res;
      logic signed [127:0] ct, r[3], b[3], b2, dot, t1, t2, k, diff, p, ctc;
      logic [63:0] s;
      logic [127:0] g, gm1, num, den;
      bit bad, sat;
      logic [31:0] o[3];
      bad = 1'b0;
      sat = 1'b0;
      ct = $signed(v.t);
      r[0] = $signed(v.x); r[1] = $signed(v.y); r[2] = $signed(v.z);
      b[0] = $signed(v.bx); b[1] = $signed(v.by); b[2] = $signed(v.bz);
      b2 = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         if (b[i] == -32768) bad = 1'b1;
         b2 += b[i] * b[i];
         dot += b[i] * r[i];
      end
      if (b2 >= (128'sd1 << 30)) bad = 1'b1;
      if (bad) begin
         res = '{0, 0, 0, 0, ST_BAD};
         return res;
      end
      if (b2 == 0) begin
         res = '{v.t, v.x, v.y, v.z, ST_OK};
         return res;
      end
      s = int_sqrt(((64'd1 << 30) - b2[63:0]) << 32);
      g = (128'd1 << 63) / s;
      gm1 = g - (128'd1 << 32);
      // (gamma-1)*dot / (4*b2), rounded half up on the magnitude.
      num = gm1 * mag(dot);
      den = 4 * b2;
      t1 = capped(num / den + ((num % den) >= den - (num % den) ? 1 : 0), dot < 0, sat);
      t2 = capped(shr_round(g * mag(ct), 17), ct < 0, sat);
      k = t1 - t2;
      diff = ct * 32768 - dot;
      ctc = capped(shr_round(g * mag(diff), 47), diff < 0, sat);
      res.t = clamp32(ctc, sat);
      for (int i = 0; i < 3; i++) begin
         p = capped(shr_round(mag(b[i]) * mag(k), 30), (b[i] < 0) != (k < 0), sat);
         o[i] = clamp32(r[i] + p, sat);
      end
      res.x = o[0]; res.y = o[1]; res.z = o[2];
      res.status = sat ? ST_SAT : ST_OK;
      return res;
   endfunction

   // Random velocity component, mostly small enough to keep beta physical.
   function automatic logic [15:0] rand_beta(input int span);
      return 16'($signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2 ** 24)) - 2 ** 23);
         default: return 32'($signed($urandom_range(2 ** 18)) - 2 ** 17);
      endcase
   endfunction

   // Fill the queue of pending items.
   initial begin
      vec_item_type v;
      logic [31:0] ext[4];
      ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
      // Zero beta passes through; extremes of the vector fields.
      for (int i = 0; i < 4; i++) pending_vectors.push_back('{ext[i], ext[(i + 1) % 4],
         ext[(i + 2) % 4], ext[(i + 3) % 4], 16'd0, 16'd0, 16'd0});
      // A beta component at minus one.
      pending_vectors.push_back('{32'h10000, 1, 2, 3, 16'h8000, 0, 0});
      pending_vectors.push_back('{32'h10000, 1, 2, 3, 0, 16'h8000, 0});
      pending_vectors.push_back('{32'h10000, 1, 2, 3, 0, 0, 16'h8000});
      // Beta squared at or above one, and just below.
      pending_vectors.push_back('{32'h10000, 1, 2, 3, 16'h7FFF, 16'h7FFF, 0});
      pending_vectors.push_back('{32'h10000, 1, 2, 3, 16'h5A83, 16'h5A83, 0});
      pending_vectors.push_back('{32'h10000, 32'h20000, 0, 0, 16'h7FFF, 0, 0});
      pending_vectors.push_back('{32'h10000, 32'h20000, 32'h3000, 5, 16'h8001, 0, 0});
      // Saturation at large gamma and large vectors.
      pending_vectors.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 16'h7FF0, 0, 0});
      pending_vectors.push_back('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 0, 16'h7000, 16'h1000});
      pending_vectors.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         32'h0004_0000, 16'h1000, 16'hF000, 16'h0800});
      pending_vectors.push_back('{32'hFFFF_0000, 32'h0, 32'h0, 32'h1, 16'h0001, 16'hFFFF, 0});
      // Random items.
      for (int n = 0; n < 500; n++) begin
         v.t = rand_coord(); v.x = rand_coord(); v.y = rand_coord(); v.z = rand_coord();
         case ($urandom_range(9))
            0: begin
               v.bx = $urandom; v.by = $urandom; v.bz = $urandom;
            end
            1: begin
               v.bx = 0; v.by = 0; v.bz = 0;
            end
            2: begin
               v.bx = rand_beta(32767); v.by = 0; v.bz = 0;
            end
            default: begin
               v.bx = rand_beta(18900); v.by = rand_beta(18900); v.bz = rand_beta(18900);
            end
         endcase
         pending_vectors.push_back(v);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Driver: present items at the falling edge.
   always @(negedge clock) begin
      bit accepted;
      accepted = req_valid && !req_stall_q;
      if (!reset) begin
         if (accepted && pending_vectors.size() > 0) void'(pending_vectors.pop_front());
         if ((!req_valid || accepted) && pending_vectors.size() > 0 &&
             (steady_phase || $urandom_range(99) >= 23)) begin
            req_valid <= 1'b1;
            req_time_component <= pending_vectors[0].t;
            req_space_x <= pending_vectors[0].x;
            req_space_y <= pending_vectors[0].y;
            req_space_z <= pending_vectors[0].z;
            req_velocity_x <= pending_vectors[0].bx;
            req_velocity_y <= pending_vectors[0].by;
            req_velocity_z <= pending_vectors[0].bz;
         end else if (!req_valid || accepted) begin
            req_valid <= 1'b0;
         end
         rsp_stall <= steady_phase ? 1'b0 : ($urandom_range(99) < 23);
      end
   end

   // Monitor: predict on acceptance, check results.
   always @(posedge clock) begin
      boost_item_type want;
      boost_item_type got;
      bit moved;
      moved = 1'b0;
      req_stall_q <= req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_boosts.push_back(boost_vector('{req_time_component, req_space_x,
               req_space_y, req_space_z, req_velocity_x, req_velocity_y, req_velocity_z}));
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = '{rsp_boosted_time, rsp_boosted_x, rsp_boosted_y, rsp_boosted_z, rsp_status};
            if (expected_boosts.size() == 0) begin
               report_mismatch("result with nothing expected", 0, 0);
            end else begin
               want = expected_boosts.pop_front();
               if (got.t !== want.t) report_mismatch("boosted_time", got.t, want.t);
               if (got.x !== want.x) report_mismatch("boosted_x", got.x, want.x);
               if (got.y !== want.y) report_mismatch("boosted_y", got.y, want.y);
               if (got.z !== want.z) report_mismatch("boosted_z", got.z, want.z);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
         idle_count <= moved ? 0 : idle_count + 1;
      end
   end

   // One line per mismatch.
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
   endtask

   // A stretch with no idling on either side, in the middle of the random part.
   always @(posedge clock) begin
      steady_phase <= pending_vectors.size() < 300 && pending_vectors.size() > 180;
   end

   // Watchdog.
   always @(posedge clock) begin
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // End of run.
   initial begin
      wait (stimulus_done);
      wait (pending_vectors.size() == 0 && expected_boosts.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_boosts.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
